// ===== src/lsse_pkg.sv =====
package lsse_pkg;

  // Fixed field widths
  localparam int ELEM_W   = 9;   // element_index, element_count
  localparam int SETSZ_W  = 6;   // max_set_size
  localparam int SQ_W     = 6;   // square_number
  localparam int BP_W     = 10;  // bit_position

  // Configuration register indexes
  localparam logic CFG_IDX_ELEMENT_COUNT = 1'b0;
  localparam logic CFG_IDX_MAX_SET_SIZE  = 1'b1;

  // Reset values of the configuration registers
  localparam int RST_ELEMENT_COUNT = 256;
  localparam logic [SETSZ_W-1:0] RST_MAX_SET_SIZE = 6'd3;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_FLUSH
  } back_state_t;

  // One result item
  typedef struct packed {
    logic             in_range;
    logic [BP_W-1:0]  bit_position;
    logic [SQ_W-1:0]  square_number;
  } out_item_t;

  // Smallest side s with s*s >= n, for sides up to max_side (at most 64)
  function automatic logic [6:0] side_of(input logic [ELEM_W-1:0] n, input int max_side);
    logic [6:0] s;
    s = 7'd0;
    for (int k = 1; k <= 64; k++) begin
      if (k <= max_side && (k - 1) * (k - 1) < int'(n)) begin
        s = 7'(k);
      end
    end
    return s;
  endfunction

endpackage

// ===== src/lsse_front.sv =====
module lsse_front import lsse_pkg::*; #(
  parameter int SIDE_W = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ELEM_W-1:0]     element_index,
  input  logic [ELEM_W-1:0]     n_eff,
  input  logic [SIDE_W-1:0]     side,
  output logic                  push,
  output logic [2*SIDE_W:0]     push_data,   // {in_range, row, col}
  input  logic                  full
);

  front_state_t         state_r, state_nxt;
  logic [ELEM_W-1:0]    rem_r, rem_nxt;
  logic [SIDE_W-1:0]    row_r, row_nxt;
  logic                 ir_r, ir_nxt;
  logic [ELEM_W-1:0]    side_ext;
  logic                 ok;

  assign side_ext = {{(ELEM_W-SIDE_W){1'b0}}, side};

  // Classify the incoming index
  assign ok = (element_index != '0) && (element_index <= n_eff) && (side != '0);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    row_r <= row_nxt;
    ir_r  <= ir_nxt;
  end

  // Split position into row and column by repeated subtraction of the side
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    row_nxt   = row_r;
    ir_nxt    = ir_r;
    in_tready = 1'b0;
    push      = 1'b0;
    push_data = {ir_r, row_r, rem_r[SIDE_W-1:0]};
    case (state_r)
      F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ir_nxt    = ok;
          rem_nxt   = ok ? element_index - ELEM_W'(1) : '0;
          row_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (ir_r && rem_r >= side_ext) begin
          rem_nxt = rem_r - side_ext;
          row_nxt = row_r + SIDE_W'(1);
        end else if (!full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lsse_fifo.sv =====
module lsse_fifo #(
  parameter int W     = 11,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  output logic          full,
  input  logic          pop,
  output logic [W-1:0]  pop_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]      mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (pop && !empty) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/lsse_back.sv =====
module lsse_back import lsse_pkg::*; #(
  parameter int SIDE_W      = 5,
  parameter int MAX_SQUARES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  logic [2*SIDE_W:0]   pop_data,    // {in_range, row, col}
  output logic                pop,
  input  logic [SIDE_W-1:0]   side,
  input  logic [SETSZ_W-1:0]  max_set_size,
  output logic                out_tvalid,
  input  logic                out_tready,
  output out_item_t           out_item,
  output logic                out_tlast
);

  localparam int IT_W = $clog2(MAX_SQUARES);

  back_state_t        state_r, state_nxt;
  logic [SIDE_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [SIDE_W-1:0]  inc_r, inc_nxt, start_r, start_nxt, acc_r, acc_nxt;
  logic               mir_r, mir_nxt;
  logic [IT_W-1:0]    it_r, it_nxt;
  logic [SQ_W-1:0]    cnt_r, cnt_nxt;
  logic [BP_W-1:0]    base_r, base_nxt;
  out_item_t          hold_r, hold_nxt;
  logic               hold_v_r, hold_v_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_v_r, out_v_nxt, out_last_r, out_last_nxt;

  logic               out_free, load;
  logic [IT_W-1:0]    last_it;
  logic [SIDE_W-1:0]  c, sym, sym_gen, inc1, inc2, start1, acc1, acc2, inc_init;
  logic               emit;
  logic [BP_W-1:0]    side_bp;

  // Add two residues below the side, result reduced once
  function automatic logic [SIDE_W-1:0] mod_add(input logic [SIDE_W-1:0] a,
                                                input logic [SIDE_W-1:0] b,
                                                input logic [SIDE_W-1:0] m);
    logic [SIDE_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[SIDE_W-1:0];
  endfunction

  assign out_free   = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_item   = out_r;
  assign out_tlast  = out_last_r;
  assign side_bp    = BP_W'(side);
  assign inc_init   = (side == SIDE_W'(1)) ? '0 : SIDE_W'(1);

  // Final iteration index: set size, capped by the square count
  assign last_it = (int'(max_set_size) > MAX_SQUARES - 1) ? IT_W'(MAX_SQUARES - 1)
                                                          : IT_W'(max_set_size);

  // Symbol of a generated square and the step of inc, start and row*inc
  always_comb begin
    c       = mir_r ? (side - SIDE_W'(1) - col_r) : col_r;
    sym_gen = mod_add(mod_add(c, acc_r, side), start_r, side);
    inc1    = (inc_r + SIDE_W'(1) == side) ? '0 : inc_r + SIDE_W'(1);
    acc1    = mod_add(acc_r, row_r, side);
    start1  = (start_r + SIDE_W'(1) == side) ? '0 : start_r + SIDE_W'(1);
    inc2    = (side == SIDE_W'(1)) ? '0 : SIDE_W'(1);
    acc2    = mod_add(acc1, row_r, side);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    inc_r      <= inc_nxt;
    start_r    <= start_nxt;
    acc_r      <= acc_nxt;
    mir_r      <= mir_nxt;
    it_r       <= it_nxt;
    cnt_r      <= cnt_nxt;
    base_r     <= base_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // Sequence the squares of one entry; hold one result back to mark the last
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    inc_nxt      = inc_r;
    start_nxt    = start_r;
    acc_nxt      = acc_r;
    mir_nxt      = mir_r;
    it_nxt       = it_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    pop          = 1'b0;
    load         = 1'b0;
    emit         = 1'b1;
    sym          = sym_gen;
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (pop_data[2*SIDE_W]) begin
            row_nxt    = pop_data[2*SIDE_W-1:SIDE_W];
            col_nxt    = pop_data[SIDE_W-1:0];
            inc_nxt    = inc_init;
            start_nxt  = '0;
            acc_nxt    = pop_data[2*SIDE_W-1:SIDE_W];
            mir_nxt    = 1'b0;
            it_nxt     = '0;
            cnt_nxt    = '0;
            base_nxt   = '0;
            hold_v_nxt = 1'b0;
            state_nxt  = B_RUN;
          end else begin
            hold_nxt   = '0;
            hold_v_nxt = 1'b1;
            state_nxt  = B_FLUSH;
          end
        end
      end
      B_RUN: begin
        if (out_free) begin
          if (it_r == '0) begin
            sym = col_r;
          end else if (it_r == IT_W'(1)) begin
            sym = row_r;
          end else if (inc1 != '0) begin
            inc_nxt = inc1;
            acc_nxt = acc1;
          end else if (start1 == '0 && !mir_r) begin
            // first full wrap of start: enter mirrored phase, drop this square
            emit      = 1'b0;
            mir_nxt   = 1'b1;
            start_nxt = '0;
            inc_nxt   = inc_init;
            acc_nxt   = row_r;
          end else begin
            start_nxt = start1;
            inc_nxt   = inc2;
            acc_nxt   = acc2;
          end
          if (emit) begin
            if (hold_v_r) begin
              load         = 1'b1;
              out_nxt      = hold_r;
              out_last_nxt = 1'b0;
            end
            hold_nxt.in_range      = 1'b1;
            hold_nxt.square_number = cnt_r;
            hold_nxt.bit_position  = BP_W'(sym) + base_r;
            hold_v_nxt             = 1'b1;
            cnt_nxt                = cnt_r + SQ_W'(1);
            base_nxt               = base_r + side_bp;
          end
          it_nxt = it_r + IT_W'(1);
          if (it_r == last_it) begin
            state_nxt = B_FLUSH;
          end
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          load         = 1'b1;
          out_nxt      = hold_r;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    // Output register: fill on load, drain on transaction
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

endmodule

// ===== src/latin_square_sketch_encoder.sv =====
// Channel  Direction  Payload                                  Handshake
// in_      slave      tdata[8:0] element_index                  tvalid/tready
// out_     master     tdata {bit_position, square_number},      tvalid/tready
//                     tuser in_range, tlast last
// cfg_     slave      index 0 element_count, 1 max_set_size    valid/ready
//
// The front splits index-1 into row and column by subtracting the side once a
// cycle; it takes no new index until it pushes. A two-entry queue feeds the
// back, which takes an entry and, while the output is free, steps one iteration
// a cycle (one square each, none at the first wrap), then releases the held
// last result, one zero item if out of range. The slower side sets the rate.
// Reset (rst_n low, synchronous) empties the queue and clears both sides.
// A stalled output holds the back; a full queue holds the front.
module latin_square_sketch_encoder import lsse_pkg::*; #(
  parameter int MAX_SIDE    = 16,
  parameter int MAX_SQUARES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,    // [8:0] element_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,   // [5:0] square_number, [15:6] bit_position
  output logic         out_tuser,   // [0] in_range
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int ENTRY_W = 2 * SIDE_W + 1;
  localparam int MAX_N   = MAX_SIDE * MAX_SIDE;
  localparam int RST_N   = (RST_ELEMENT_COUNT > MAX_N) ? MAX_N : RST_ELEMENT_COUNT;

  logic [ELEM_W-1:0]   n_eff_r;
  logic [SIDE_W-1:0]   side_r;
  logic [SETSZ_W-1:0]  mss_r;
  logic [ELEM_W-1:0]   cfg_n;
  logic [6:0]          cfg_side, rst_side;

  logic                push, pop, full, empty;
  logic [ENTRY_W-1:0]  push_data, pop_data;
  out_item_t           out_item;

  assign cfg_ready = 1'b1;
  assign cfg_n     = (int'(cfg_data) > MAX_N) ? ELEM_W'(MAX_N) : cfg_data;
  assign cfg_side  = side_of(cfg_n, MAX_SIDE);
  assign rst_side  = side_of(ELEM_W'(RST_N), MAX_SIDE);

  // Configuration registers; side follows the saturated element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r <= ELEM_W'(RST_N);
      side_r  <= rst_side[SIDE_W-1:0];
      mss_r   <= RST_MAX_SET_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_ELEMENT_COUNT: begin
          n_eff_r <= cfg_n;
          side_r  <= cfg_side[SIDE_W-1:0];
        end
        CFG_IDX_MAX_SET_SIZE: begin
          mss_r <= cfg_data[SETSZ_W-1:0];
        end
        default: begin
          mss_r <= mss_r;
        end
      endcase
    end
  end

  lsse_front #(
    .SIDE_W (SIDE_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .element_index (in_tdata[ELEM_W-1:0]),
    .n_eff         (n_eff_r),
    .side          (side_r),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  lsse_fifo #(
    .W     (ENTRY_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  lsse_back #(
    .SIDE_W      (SIDE_W),
    .MAX_SQUARES (MAX_SQUARES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .side         (side_r),
    .max_set_size (mss_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_item     (out_item),
    .out_tlast    (out_tlast)
  );

  assign out_tdata = {out_item.bit_position, out_item.square_number};
  assign out_tuser = out_item.in_range;

  // An out-of-range result is a single zero item that closes its element
  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == '0)
    else $error("out-of-range result not a lone zero item");

  // The queue never takes an entry while full, nor gives one while empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");

  // Side is zero exactly when the element count is zero, and within bounds
  a_side_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(side_r) <= MAX_SIDE) && ((side_r == '0) == (n_eff_r == '0)))
    else $error("side inconsistent with element count");

  // An in-range result following the last of an element starts at square zero
  a_first_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid && out_tuser
    |-> out_tdata[SQ_W-1:0] == '0)
    else $error("new element does not start at square zero");

endmodule

// ===== test/tb.sv =====
module tb;
  import lsse_pkg::*;

  localparam int MAX_SIDE    = 16;
  localparam int MAX_SQUARES = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = MAX_SQUARES + 8;
  localparam int NUM_PHASES  = 11;

  // One expected result, kept with its last flag
  typedef struct packed {
    logic [SQ_W-1:0] square_number;
    logic [BP_W-1:0] bit_position;
    logic            in_range;
    logic            last;
  } square_bit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IDX_ELEMENT_COUNT;
  logic [8:0]  cfg_data = '0;

  // Shadow copy of the configuration
  logic [8:0]         elem_count = 9'(RST_ELEMENT_COUNT);
  logic [SETSZ_W-1:0] set_size   = RST_MAX_SET_SIZE;

  logic [ELEM_W-1:0] index_q[$];
  square_bit_t       bits_q[$];
  int                mismatches = 0;
  int                in_gap = 0;
  int                out_gap = 0;
  bit                in_burst = 1'b0;
  bit                out_burst = 1'b0;
  int                idle_cycles = 0;

  latin_square_sketch_encoder #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_SQUARES(MAX_SQUARES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Work out the set bits that one element index produces
  task automatic predict_squares(input logic [ELEM_W-1:0] idx);
    int          n, s, pos, row, col, iters, inc, start, c, sym, cnt;
    bit          mirrored;
    square_bit_t r;
    n = elem_count;
    if (n > MAX_SIDE * MAX_SIDE) n = MAX_SIDE * MAX_SIDE;
    s = 0;
    while (s * s < n) s++;
    if (idx < 1 || idx > n || s == 0) begin
      r = '{square_number: '0, bit_position: '0, in_range: 1'b0, last: 1'b1};
      bits_q.insert(bits_q.size(), r);
      return;
    end
    pos = idx - 1;
    row = pos / s;
    col = pos % s;
    iters = set_size + 1;
    if (iters > MAX_SQUARES) iters = MAX_SQUARES;
    inc = 1;
    start = 0;
    mirrored = 1'b0;
    cnt = 0;
    for (int it = 0; it < iters; it++) begin
      if (it == 0) begin
        sym = col;
      end else if (it == 1) begin
        sym = row;
      end else begin
        c = mirrored ? (s - 1 - col) : col;
        sym = (c + row * inc + start) % s;
        inc++;
        if (inc % s == 0) begin
          start++;
          // first full wrap of start: switch to mirrored columns, emit nothing
          if (start % s == 0 && !mirrored) begin
            mirrored = 1'b1;
            start = 0;
            inc = 1;
            continue;
          end
          inc++;
        end
      end
      r.square_number = SQ_W'(cnt);
      r.bit_position  = BP_W'(sym + cnt * s);
      r.in_range      = 1'b1;
      r.last          = 1'b0;
      bits_q.insert(bits_q.size(), r);
      cnt++;
    end
    bits_q[bits_q.size() - 1].last = 1'b1;
  endtask

  // Mostly valid indexes, with boundaries, zero and out-of-range noise
  function automatic logic [ELEM_W-1:0] pick_index();
    int n, r;
    n = elem_count;
    if (n > MAX_SIDE * MAX_SIDE) n = MAX_SIDE * MAX_SIDE;
    r = $urandom_range(0, 19);
    if (n >= 1 && r < 14) return ELEM_W'($urandom_range(1, n));
    if (n >= 1 && r == 14) return ELEM_W'(n);
    if (r == 15) return ELEM_W'(1);
    if (r == 16) return '0;
    if (r == 17) return ELEM_W'(n + 1);
    return ELEM_W'($urandom_range(0, 511));
  endfunction

  // Input driver: predict on each accepted transaction, then present the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_squares(in_tdata[ELEM_W-1:0]);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (index_q.size() > 0) begin
          in_tdata  <= {7'd0, index_q.pop_front()};
          in_tvalid <= 1'b1;
          in_gap = in_burst ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    square_bit_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (bits_q.size() == 0) begin
          report_mismatch("unexpected result, bit_position", int'(out_tdata[15:6]), -1);
        end else begin
          want = bits_q.pop_front();
          if (out_tdata[5:0] !== want.square_number)
            report_mismatch("square_number", int'(out_tdata[5:0]),
                            int'(want.square_number));
          if (out_tdata[15:6] !== want.bit_position)
            report_mismatch("bit_position", int'(out_tdata[15:6]),
                            int'(want.bit_position));
          if (out_tuser !== want.in_range)
            report_mismatch("in_range", int'(out_tuser), int'(want.in_range));
          if (out_tlast !== want.last)
            report_mismatch("last", int'(out_tlast), int'(want.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = out_burst ? 0 : pick_gap();
      end
    end
  end

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_ELEMENT_COUNT) elem_count <= cfg_data;
      else set_size <= cfg_data[SETSZ_W-1:0];
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: timeout");
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold valid until the write transaction completes; caller lowers it
  task automatic cfg_write(input logic idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (index_q.size() > 0 || in_tvalid || bits_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int counts[NUM_PHASES];
    int sizes[NUM_PHASES];
    counts = '{256, 1, 256, 511, 0, 2, 10, 100, 17, 3, 0};
    sizes  = '{3, 0, 63, 63, 5, 63, 12, 3, 20, 63, 0};
    counts[9]  = $urandom_range(1, 64);
    counts[10] = $urandom_range(1, 300);
    sizes[10]  = $urandom_range(0, 63);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset configuration
    index_q = '{9'd0, 9'd1, 9'd256, 9'd257, 9'd511, 9'd16, 9'd17, 9'd255, 9'd241,
                9'd128, 9'd85, 9'd170, 9'd2, 9'd15, 9'd400};
    in_burst = 1'b1;
    out_burst = 1'b1;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        cfg_write(CFG_IDX_ELEMENT_COUNT, 9'(counts[p]));
        cfg_write(CFG_IDX_MAX_SET_SIZE, {3'($urandom_range(0, 7)), 6'(sizes[p])});
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      // Wait until the register writes have landed before picking indexes
      @(posedge clk);
      for (int k = 0; k < 33; k++) index_q.insert(index_q.size(), pick_index());
      drain();
    end

    while (bits_q.size() > 0) begin
      report_mismatch("missing result, bit_position", -1, int'(bits_q[0].bit_position));
      void'(bits_q.pop_front());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
